// ----- hdl/bhtlp_pkg.sv -----
// Package for the bucketed hash table: widths, status codes and defaults.
// No dependencies.
`default_nettype none
package bhtlp_pkg;
  localparam int unsigned BUCKETS_DEF = 32;
  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned KEY_W       = 52;
  localparam int unsigned PAY_W       = 64;
  localparam int unsigned DIV_W       = 6;
  localparam logic [DIV_W-1:0] DIV_RESET = 6'd31;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic       lookup;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [PAY_W-1:0] found_payload;
    logic [4:0] bucket_index;
    logic [3:0] slot_index;
  } rsp_t;
endpackage
`default_nettype wire

// ----- hdl/bhtlp_if.sv -----
// Valid/ready channel interfaces for request, result and configuration items.
// Depends on bhtlp_pkg.
`default_nettype none
interface bhtlp_req_if import bhtlp_pkg::*; ();
  logic valid;
  logic ready;
  logic req_type;
  logic [KEY_W-1:0] key_digits;
  logic [PAY_W-1:0] payload_word;
  modport source (output valid, req_type, key_digits, payload_word, input ready);
  modport sink (input valid, req_type, key_digits, payload_word, output ready);
endinterface

interface bhtlp_rsp_if import bhtlp_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [PAY_W-1:0] found_payload;
  logic [4:0] bucket_index;
  logic [3:0] slot_index;
  modport source (output valid, status, found_payload, bucket_index, slot_index,
                  input ready);
  modport sink (input valid, status, found_payload, bucket_index, slot_index,
                output ready);
endinterface

interface bhtlp_cfg_if import bhtlp_pkg::*; ();
  logic valid;
  logic ready;
  logic [DIV_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/bhtlp_home.sv -----
// Home bucket unit: folds the key, then a shift-subtract remainder, one bit a cycle.
// Depends on bhtlp_pkg.
`default_nettype none
module bhtlp_home import bhtlp_pkg::*; #(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic [BW-1:0]         home
);
  localparam int unsigned SUM_W = 16;
  localparam int unsigned CNT_W = 4;

  logic [SUM_W-1:0] sum;
  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] div;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [SUM_W-1:0] fold;

  function automatic logic [SUM_W-1:0] dig(input logic [KEY_W-1:0] k, input int d);
    dig = SUM_W'(k[48-4*d +: 4]);
  endfunction

  function automatic logic [SUM_W-1:0] grp(input logic [KEY_W-1:0] k,
      input int d3, input int d2, input int d1, input int d0);
    grp = SUM_W'(dig(k, d3) * 1000) + SUM_W'(dig(k, d2) * 100) +
          SUM_W'(dig(k, d1) * 10) + dig(k, d0);
  endfunction

  // remainder wrapped onto the table: constant table over every divisor remainder
  function automatic logic [BW-1:0] bucket_wrap(input logic [DIV_W-1:0] r);
    bucket_wrap = '0;
    for (int i = 0; i < (1 << DIV_W); i++)
      if (r == DIV_W'(i)) bucket_wrap = BW'(i % BUCKETS);
  endfunction

  assign fold  = grp(key, 4, 5, 6, 7) + grp(key, 3, 2, 1, 0) + grp(key, 11, 10, 9, 8);
  assign trial = {rem[DIV_W-1:0], sum[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sum  <= fold;
        rem  <= '0;
        div  <= divisor;
      end else if (busy) begin
        sum <= sum << 1;
        if (trial >= {1'b0, div}) rem <= trial - {1'b0, div};
        else rem <= trial;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rem < divisor once finished; zero divisor leaves rem = fold bits, forced to 0
  always_comb begin
    if (div == '0) home = '0;
    else home = bucket_wrap(rem[DIV_W-1:0]);
  end
endmodule
`default_nettype wire

// ----- hdl/bucketed_hash_table_linear_probe.sv -----
// Bucketed hash table with linear probing over buckets.
// The home bucket is computed first, then each probed slot is read, then compared; the
// result is offered once a match, a free slot or the end of the probe is found.
// Throughput: one item at a time, as no new request is taken until the result is accepted;
// set by the serial remainder and the slot-by-slot probe. Reset: clears control and sets the
// divisor to 31, then a clearing pass empties all BUCKETS*SLOTS entries before the first item.
`default_nettype none
module bucketed_hash_table_linear_probe import bhtlp_pkg::*; #(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned SLOTS   = SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  bhtlp_req_if.sink   req,
  bhtlp_rsp_if.source rsp,
  bhtlp_cfg_if.sink   cfg
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned N  = BUCKETS * SLOTS;
  localparam int unsigned AW = $clog2(N);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  entry_t mem [N];
  entry_t rd;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata;

  state_t state;
  logic [DIV_W-1:0] divisor;
  req_t  cur;
  rsp_t  res;
  logic [BW-1:0] bkt;
  logic [SW-1:0] slt;
  logic [BW:0]   steps;
  logic [AW:0]   clr;
  logic          hstart, hdone;
  logic [BW-1:0] home;
  logic          last_slot, last_bkt;

  bhtlp_home #(.BUCKETS(BUCKETS)) u_home (
    .clk(clk), .rst(rst), .start(hstart), .key(cur.key),
    .divisor(divisor), .done(hdone), .home(home)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == S_OUT);
  assign rsp.status        = res.status;
  assign rsp.found_payload = res.found_payload;
  assign rsp.bucket_index  = res.bucket_index;
  assign rsp.slot_index    = res.slot_index;

  assign raddr     = AW'(32'(bkt) * SLOTS + 32'(slt));
  assign last_slot = (slt == SW'(SLOTS-1));
  assign last_bkt  = (steps == (BW+1)'(BUCKETS-1));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = '{occ: 1'b1, key: cur.key, payload: cur.payload};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr[AW-1:0];
      wdata = '0;
    end else if (state == S_CHECK && !rd.occ && !cur.lookup) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      divisor <= DIV_RESET;
      hstart  <= 1'b0;
    end else begin
      hstart <= 1'b0;
      if (cfg.valid) divisor <= cfg.data;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(N-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            cur    <= '{lookup: req.req_type, key: req.key_digits,
                        payload: req.payload_word};
            hstart <= 1'b1;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          if (hdone) begin
            bkt   <= home;
            slt   <= '0;
            steps <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (rd.occ && rd.key == cur.key) begin
            res   <= '{status: cur.lookup ? ST_FOUND : ST_DUPLICATE,
                       found_payload: cur.lookup ? rd.payload : '0,
                       bucket_index: 5'(bkt), slot_index: 4'(slt)};
            state <= S_OUT;
          end else if (!rd.occ && !cur.lookup) begin
            res   <= '{status: ST_INSERTED, found_payload: '0,
                       bucket_index: 5'(bkt), slot_index: 4'(slt)};
            state <= S_OUT;
          end else if (!rd.occ || (last_slot && last_bkt)) begin
            res   <= '{status: cur.lookup ? ST_NOT_FOUND : ST_FULL, found_payload: '0,
                       bucket_index: '0, slot_index: '0};
            state <= S_OUT;
          end else begin
            state <= S_READ;
            if (last_slot) begin
              slt   <= '0;
              steps <= steps + 1'b1;
              bkt   <= (bkt == BW'(BUCKETS-1)) ? '0 : bkt + 1'b1;
            end else begin
              slt <= slt + 1'b1;
            end
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("request taken during clear");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status)))
    else $error("result dropped");
  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    (we && state != S_CLEAR) |-> !cur.lookup)
    else $error("lookup wrote memory");
`endif
endmodule
`default_nettype wire
